@@ sv/pq_nearest_center_assign_top_macros.svh @@
// ----------------------------------------------------------------------------
// pq_nearest_center_assign_top_macros.svh
// Assertion macros used by the checker of the nearest-center block.
// ----------------------------------------------------------------------------
`ifndef PQ_NEAREST_CENTER_ASSIGN_TOP_MACROS_SVH
`define PQ_NEAREST_CENTER_ASSIGN_TOP_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define PQNCA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define PQNCA_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/pqnca_pkg.sv @@
// ----------------------------------------------------------------------------
// pqnca_pkg
// Types and constants of the product-quantization nearest-center block.
// ----------------------------------------------------------------------------
package pqnca_pkg;

	localparam int NUM_SUB_DEF      = 8;
	localparam int MAX_CLUSTERS_DEF = 1024;
	localparam int MAX_SUB          = 8;

	// fixed table layout: sub*65536 + a*256 + b
	localparam int CODE_BITS  = 8;
	localparam int BANK_AW    = 2 * CODE_BITS;
	localparam int BANK_DEPTH = 1 << BANK_AW;

	localparam logic [10:0] NUM_CLUSTERS_RST = 11'd256;

	// request opcodes
	localparam logic [1:0] OP_LOAD_DIST   = 2'd0;
	localparam logic [1:0] OP_LOAD_CENTER = 2'd1;
	localparam logic [1:0] OP_ASSIGN      = 2'd2;

	typedef struct packed {
		logic [1:0]  op;
		logic [18:0] index;
		logic [31:0] dist_value;
		logic [63:0] point_codes;
		logic [9:0]  prev_label;
	} in_item_t;

	typedef struct packed {
		logic [9:0]  cluster_label;
		logic [34:0] min_distance;
		logic        label_changed;
	} out_item_t;

	typedef struct packed {
		logic wr_dist;
		logic wr_center;
		logic load_query;
		logic issue;
	} dp_cmd_t;

	typedef struct packed {
		logic pipe_busy;
	} dp_stat_t;

endpackage

@@ sv/pqnca_dpath.sv @@
// ----------------------------------------------------------------------------
// pqnca_dpath
// Center store, banked distance table and the compare pipeline.
// ----------------------------------------------------------------------------
module pqnca_dpath #(
	parameter int NUM_SUB      = pqnca_pkg::NUM_SUB_DEF,
	parameter int MAX_CLUSTERS = pqnca_pkg::MAX_CLUSTERS_DEF,
	localparam int CW = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  pqnca_pkg::dp_cmd_t   cmd,
	input  logic [CW-1:0]        rd_addr,
	input  pqnca_pkg::in_item_t  item,
	output pqnca_pkg::dp_stat_t  stat,
	output pqnca_pkg::out_item_t result
);

	logic [63:0]   center_mem [MAX_CLUSTERS];
	logic [63:0]   point_q;
	logic [9:0]    prev_q;

	logic [63:0]   code_s1;
	logic [31:0]   rd_s2 [NUM_SUB];
	logic [31:0]   lane [pqnca_pkg::MAX_SUB];
	logic [33:0]   sum_lo_s3, sum_hi_s3;
	logic [34:0]   total;
	logic [34:0]   best_q;
	logic [CW-1:0] best_label_q;
	logic          v_s1, v_s2, v_s3;
	logic [CW-1:0] label_s1, label_s2, label_s3;
	logic [9:0]    label_out;

	always_ff @(posedge clk) begin
		if (cmd.load_query) begin
			point_q <= item.point_codes;
			prev_q  <= item.prev_label;
		end
	end

	// stage 1: center code read
	always_ff @(posedge clk) begin
		if (cmd.wr_center && item.index < 19'(MAX_CLUSTERS))
			center_mem[item.index[CW-1:0]] <= item.point_codes;
		code_s1 <= center_mem[rd_addr];
	end

	// stage 2: one table bank per subspace
	for (genvar s = 0; s < NUM_SUB; s++) begin : g_bank
		logic [31:0]                     mem [pqnca_pkg::BANK_DEPTH];
		logic [pqnca_pkg::BANK_AW-1:0] raddr;

		assign raddr = {code_s1[8*s +: 8], point_q[8*s +: 8]};

		always_ff @(posedge clk) begin
			if (cmd.wr_dist && item.index[18:16] == 3'(s))
				mem[item.index[15:0]] <= item.dist_value;
			rd_s2[s] <= mem[raddr];
		end
	end

	for (genvar l = 0; l < pqnca_pkg::MAX_SUB; l++) begin : g_lane
		if (l < NUM_SUB) begin : g_used
			assign lane[l] = rd_s2[l];
		end else begin : g_unused
			assign lane[l] = '0;
		end
	end

	// stage 3: two partial sums of four
	always_ff @(posedge clk) begin
		sum_lo_s3 <= 34'(lane[0]) + 34'(lane[1]) + 34'(lane[2]) + 34'(lane[3]);
		sum_hi_s3 <= 34'(lane[4]) + 34'(lane[5]) + 34'(lane[6]) + 34'(lane[7]);
	end

	assign total = 35'(sum_lo_s3) + 35'(sum_hi_s3);

	// stage 4: keep the strict minimum, first center always taken
	always_ff @(posedge clk) begin
		if (v_s3 && (label_s3 == '0 || total < best_q)) begin
			best_q       <= total;
			best_label_q <= label_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		label_s1 <= rd_addr;
		label_s2 <= label_s1;
		label_s3 <= label_s2;
	end

	assign stat.pipe_busy = v_s1 | v_s2 | v_s3;

	assign label_out = 10'(best_label_q);

	always_comb begin
		result.cluster_label = label_out;
		result.min_distance  = best_q;
		result.label_changed = (label_out != prev_q);
	end

endmodule

@@ sv/pqnca_ctrl.sv @@
// ----------------------------------------------------------------------------
// pqnca_ctrl
// Request sequencer: loads, center sweep, pipeline drain, result strobe.
// ----------------------------------------------------------------------------
module pqnca_ctrl #(
	parameter int MAX_CLUSTERS = pqnca_pkg::MAX_CLUSTERS_DEF,
	localparam int CW = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [1:0]          op,
	input  logic [10:0]         num_clusters,
	input  pqnca_pkg::dp_stat_t stat,
	output pqnca_pkg::dp_cmd_t  cmd,
	output logic [CW-1:0]       rd_addr,
	output logic                busy,
	output logic                done
);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_RUN   = 4'b0010,
		S_DRAIN = 4'b0100,
		S_DONE  = 4'b1000
	} state_t;

	state_t        state_q, state_d;
	logic [CW-1:0] k_q, last_q;
	logic [12:0]   active;
	logic          accept;

	// clamp the center count to 1 .. MAX_CLUSTERS
	always_comb begin
		if (num_clusters == '0)
			active = 13'd1;
		else if (13'(num_clusters) > 13'(MAX_CLUSTERS))
			active = 13'(MAX_CLUSTERS);
		else
			active = 13'(num_clusters);
	end

	assign accept = start && (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:  if (accept && op == pqnca_pkg::OP_ASSIGN) state_d = S_RUN;
			S_RUN:   if (k_q == last_q) state_d = S_DRAIN;
			S_DRAIN: if (!stat.pipe_busy) state_d = S_DONE;
			S_DONE:  state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			k_q     <= '0;
			last_q  <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				k_q    <= '0;
				last_q <= CW'(active - 13'd1);
			end else if (state_q == S_RUN) begin
				k_q <= k_q + CW'(1);
			end
		end
	end

	always_comb begin
		cmd.wr_dist    = accept && op == pqnca_pkg::OP_LOAD_DIST;
		cmd.wr_center  = accept && op == pqnca_pkg::OP_LOAD_CENTER;
		cmd.load_query = accept && op == pqnca_pkg::OP_ASSIGN;
		cmd.issue      = (state_q == S_RUN);
	end

	assign rd_addr = k_q;
	assign busy    = (state_q != S_IDLE);
	assign done    = (state_q == S_DONE);

endmodule

@@ sv/pq_nearest_center_assign_top.sv @@
// ----------------------------------------------------------------------------
// pq_nearest_center_assign_top
// Assignment step of product-quantization k-means.
// ----------------------------------------------------------------------------
// Requests enter on item, taken at a clock edge with start high and busy low.
// A distance load (op 0) writes one table entry and a center load (op 1) one
// center code at that edge; neither makes busy rise or gives a result, so
// loads go one per cycle. An assign request (op 2) raises busy and sweeps
// centers 0 .. N-1, one per cycle, where N is num_clusters clamped to
// 1 .. MAX_CLUSTERS. Each center costs one center-store read and eight
// parallel bank reads of the distance table, then a partial-sum stage and an
// add-and-compare stage. done is high for one cycle once the pipeline has
// drained, with the answer on result; busy falls at the edge that ends that
// cycle, and only then is the next request taken. The receiver cannot stall:
// done is a single-cycle strobe. Opcode 3 is dropped. The APB register
// num_clusters (byte address 0) resets to 256 and is to be written only
// while busy is low; the block itself does not enforce this. Reset clears
// the sequencer and the register; the table and center store keep no reset
// and must be loaded before use.
// ----------------------------------------------------------------------------
module pq_nearest_center_assign_top #(
	parameter int NUM_SUB      = pqnca_pkg::NUM_SUB_DEF,
	parameter int MAX_CLUSTERS = pqnca_pkg::MAX_CLUSTERS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  pqnca_pkg::in_item_t  item,
	output logic                 done,
	output pqnca_pkg::out_item_t result,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [2:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);

	localparam int CW = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;

	logic [10:0]         num_clusters_q;
	pqnca_pkg::dp_cmd_t  cmd;
	pqnca_pkg::dp_stat_t stat;
	logic [CW-1:0]       rd_addr;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_clusters_q <= pqnca_pkg::NUM_CLUSTERS_RST;
		end else if (psel && penable && pwrite && pready && !paddr[2]) begin
			num_clusters_q <= pwdata[10:0];
		end
	end

	assign prdata = paddr[2] ? 32'd0 : 32'(num_clusters_q);

	pqnca_ctrl #(
		.MAX_CLUSTERS(MAX_CLUSTERS)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.op          (item.op),
		.num_clusters(num_clusters_q),
		.stat        (stat),
		.cmd         (cmd),
		.rd_addr     (rd_addr),
		.busy        (busy),
		.done        (done)
	);

	pqnca_dpath #(
		.NUM_SUB     (NUM_SUB),
		.MAX_CLUSTERS(MAX_CLUSTERS)
	) u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.rd_addr(rd_addr),
		.item   (item),
		.stat   (stat),
		.result (result)
	);

endmodule

@@ sv/pqnca_checker.sv @@
// ----------------------------------------------------------------------------
// pqnca_checker
// Port-level checks of request handling and the result strobe.
// ----------------------------------------------------------------------------
`include "pq_nearest_center_assign_top_macros.svh"

module pqnca_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                start,
	input logic                busy,
	input pqnca_pkg::in_item_t item,
	input logic                done
);

	`PQNCA_ASSERT_NOW(a_done_while_busy, done, busy, "result strobe outside busy")
	`PQNCA_ASSERT_NXT(a_done_single, done, !done && !busy, "strobe longer than one cycle")
	`PQNCA_ASSERT_NXT(a_assign_busy, start && !busy && item.op == pqnca_pkg::OP_ASSIGN, busy && !done, "assign request did not raise busy")
	`PQNCA_ASSERT_NXT(a_load_idle, start && !busy && item.op != pqnca_pkg::OP_ASSIGN, !busy && !done, "load request raised busy")

endmodule

bind pq_nearest_center_assign_top pqnca_checker u_pqnca_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.busy  (busy),
	.item  (item),
	.done  (done)
);

@@ verif/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the product-quantization nearest-center block.
// Loads distance entries and center codes, sends assign requests under
// several cluster counts with random gaps on the request side, and checks
// every label, summed distance and label-changed flag against a search
// model kept in the bench. Table and center entries are always loaded
// before an assign can read them.
// ----------------------------------------------------------------------------
module tb;

	localparam int         TABLE_DEPTH       = 1 << 19;
	localparam int         MAX_CL            = pqnca_pkg::MAX_CLUSTERS_DEF;
	localparam logic [1:0] OP_UNUSED         = 2'd3;
	localparam logic [2:0] ADDR_NUM_CLUSTERS = 3'd0;
	localparam int         CYCLE_LIMIT       = 2_000_000;
	localparam int         DRAIN_CYCLES      = 16;

	class assign_tracker;
		bit [31:0] dist_mem [0:TABLE_DEPTH-1];
		bit [63:0] center_mem [0:MAX_CL-1];
		bit [10:0] clusters;
		pqnca_pkg::out_item_t expected_q [$];
		int        errors;

		function new();
			clusters = pqnca_pkg::NUM_CLUSTERS_RST;
			errors = 0;
		endfunction

		function int unsigned active();
			if (clusters == 0)
				return 1;
			if (clusters > MAX_CL)
				return MAX_CL;
			return clusters;
		endfunction

		function pqnca_pkg::out_item_t nearest(bit [63:0] query, bit [9:0] prev);
			pqnca_pkg::out_item_t res;
			bit [34:0]   sum;
			bit [34:0]   best;
			int unsigned best_k;
			best = '0;
			best_k = 0;
			for (int unsigned k = 0; k < active(); k++) begin
				sum = '0;
				for (int s = 0; s < pqnca_pkg::NUM_SUB_DEF; s++)
					sum += dist_mem[{s[2:0], center_mem[k][8*s +: 8], query[8*s +: 8]}];
				// strict compare: lower index keeps a tie
				if (k == 0 || sum < best) begin
					best = sum;
					best_k = k;
				end
			end
			res.cluster_label = best_k[9:0];
			res.min_distance  = best;
			res.label_changed = (best_k[9:0] != prev);
			return res;
		endfunction

		function void note_request(pqnca_pkg::in_item_t req);
			case (req.op)
				pqnca_pkg::OP_LOAD_DIST: dist_mem[req.index] = req.dist_value;
				pqnca_pkg::OP_LOAD_CENTER: begin
					if (req.index < MAX_CL)
						center_mem[req.index[9:0]] = req.point_codes;
				end
				pqnca_pkg::OP_ASSIGN: begin
					expected_q.insert(expected_q.size(),
						nearest(req.point_codes, req.prev_label));
				end
				default: ;
			endcase
		endfunction

		function void check_result(pqnca_pkg::out_item_t got);
			pqnca_pkg::out_item_t want;
			if (expected_q.size() == 0) begin
				$error("result with no request waiting: cluster_label %0d", got.cluster_label);
				errors++;
				return;
			end
			want = expected_q.pop_front();
			if (got.cluster_label !== want.cluster_label) begin
				$error("cluster_label: expected %0d, actual %0d",
					want.cluster_label, got.cluster_label);
				errors++;
			end
			if (got.min_distance !== want.min_distance) begin
				$error("min_distance: expected %0d, actual %0d",
					want.min_distance, got.min_distance);
				errors++;
			end
			if (got.label_changed !== want.label_changed) begin
				$error("label_changed: expected %0d, actual %0d",
					want.label_changed, got.label_changed);
				errors++;
			end
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n  = 1'b0;
	logic                 start   = 1'b0;
	logic                 busy;
	pqnca_pkg::in_item_t  item    = '0;
	logic                 done;
	pqnca_pkg::out_item_t result;
	logic                 psel    = 1'b0;
	logic                 penable = 1'b0;
	logic                 pwrite  = 1'b0;
	logic [2:0]           paddr   = '0;
	logic [31:0]          pwdata  = '0;
	logic [31:0]          prdata;
	logic                 pready;

	assign_tracker board;
	bit            tbl_ok [0:TABLE_DEPTH-1];
	bit            ctr_ok [0:MAX_CL-1];
	bit [7:0]      code_pool [0:7][0:3];
	int            burst_left = 0;
	int unsigned   cycles = 0;

	pq_nearest_center_assign_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.item    (item),
		.done    (done),
		.result  (result),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("pq_nearest_center_assign_top: mismatch");
			$finish;
		end
	end

	always @(posedge clk)
		if (arst_n && done)
			board.check_result(result);

	function automatic int pick_gap();
		int r;
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 4) begin
			burst_left = $urandom_range(10, 40);
			return 0;
		end
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 96)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	function automatic bit [31:0] pick_dist();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return 32'($urandom_range(0, 7));
			4: return '1;
			5: return '0;
			default: return $urandom;
		endcase
	endfunction

	function automatic bit [63:0] pool_code();
		bit [63:0] c;
		for (int s = 0; s < 8; s++)
			c[8*s +: 8] = code_pool[s][$urandom_range(0, 3)];
		return c;
	endfunction

	function automatic pqnca_pkg::in_item_t rand_item(logic [1:0] op);
		pqnca_pkg::in_item_t req;
		req.op          = op;
		req.index       = 19'($urandom);
		req.dist_value  = $urandom;
		req.point_codes = {$urandom, $urandom};
		req.prev_label  = 10'($urandom);
		return req;
	endfunction

	task automatic send(pqnca_pkg::in_item_t req);
		int gap;
		@(negedge clk);
		start <= 1'b1;
		item  <= req;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		board.note_request(req);
		if (req.op == pqnca_pkg::OP_LOAD_DIST)
			tbl_ok[req.index] = 1'b1;
		if (req.op == pqnca_pkg::OP_LOAD_CENTER && req.index < MAX_CL)
			ctr_ok[req.index[9:0]] = 1'b1;
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			start <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic load_dist(bit [18:0] addr, bit [31:0] value);
		pqnca_pkg::in_item_t req;
		req = rand_item(pqnca_pkg::OP_LOAD_DIST);
		req.index = addr;
		req.dist_value = value;
		send(req);
	endtask

	task automatic load_center(bit [18:0] idx, bit [63:0] code);
		pqnca_pkg::in_item_t req;
		req = rand_item(pqnca_pkg::OP_LOAD_CENTER);
		req.index = idx;
		req.point_codes = code;
		send(req);
	endtask

	task automatic assign_point(bit [63:0] query, bit [9:0] prev, bit track_prev);
		pqnca_pkg::in_item_t  req;
		pqnca_pkg::out_item_t guess;
		int unsigned n;
		bit [18:0]   addr;
		req = rand_item(pqnca_pkg::OP_ASSIGN);
		n = board.active();
		// load every table entry the search will touch
		for (int unsigned k = 0; k < n; k++)
			for (int s = 0; s < pqnca_pkg::NUM_SUB_DEF; s++) begin
				addr = {s[2:0], board.center_mem[k][8*s +: 8], query[8*s +: 8]};
				if (!tbl_ok[addr])
					load_dist(addr, pick_dist());
			end
		req.point_codes = query;
		guess = board.nearest(query, '0);
		req.prev_label = track_prev ? guess.cluster_label : prev;
		send(req);
	endtask

	task automatic fill_centers();
		for (int k = 0; k < board.active(); k++)
			if (!ctr_ok[k])
				load_center(19'(k), pool_code());
	endtask

	task automatic settle();
		@(negedge clk);
		start <= 1'b0;
		while (board.expected_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	task automatic write_clusters(bit [10:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_NUM_CLUSTERS;
		pwdata  <= {21'($urandom), value};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		board.clusters = value;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic run_random(int count, int assign_pct);
		int          r;
		int          s;
		int unsigned n;
		bit [63:0]   query;
		pqnca_pkg::in_item_t req;
		repeat (count) begin
			r = $urandom_range(0, 99);
			n = board.active();
			if (r < assign_pct) begin
				// mostly reuse codes whose table entries are already loaded
				case ($urandom_range(0, 9))
					0, 1, 2: query = board.center_mem[$urandom_range(0, n - 1)];
					3: query = {$urandom, $urandom};
					default: query = pool_code();
				endcase
				assign_point(query, 10'($urandom), 1'($urandom_range(0, 1)));
			end else if (r < assign_pct + 25) begin
				req = rand_item(pqnca_pkg::OP_LOAD_DIST);
				req.dist_value = pick_dist();
				// mostly overwrite entries that searches actually read
				if ($urandom_range(0, 2) != 0) begin
					s = $urandom_range(0, 7);
					req.index = {3'(s), code_pool[s][$urandom_range(0, 3)], 8'($urandom)};
				end
				send(req);
			end else if (r < assign_pct + 45) begin
				req = rand_item(pqnca_pkg::OP_LOAD_CENTER);
				case ($urandom_range(0, 6))
					0: req.index = 19'($urandom_range(MAX_CL, TABLE_DEPTH - 1));
					1: req.index = 19'($urandom_range(0, MAX_CL - 1));
					default: req.index = 19'($urandom_range(0, n - 1));
				endcase
				if ($urandom_range(0, 7) != 0)
					req.point_codes = pool_code();
				send(req);
			end else
				send(rand_item(OP_UNUSED));
		end
	endtask

	task automatic run_phase(bit [10:0] clusters, int count, int assign_pct);
		settle();
		write_clusters(clusters);
		fill_centers();
		run_random(count, assign_pct);
	endtask

	initial begin
		pqnca_pkg::in_item_t req;
		bit [63:0]           query;
		board = new();
		foreach (code_pool[s, j])
			code_pool[s][j] = 8'($urandom);
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset cluster count
		fill_centers();
		load_dist('1, '1);
		req = '1;
		req.op = pqnca_pkg::OP_LOAD_CENTER;
		send(req);
		load_center(19'(MAX_CL), {$urandom, $urandom});
		req = '1;
		req.op = OP_UNUSED;
		send(req);
		req = '0;
		req.op = OP_UNUSED;
		send(req);

		// tie between centers 0 and 1 at distance zero
		load_center(19'd1, board.center_mem[0]);
		query = {$urandom, $urandom};
		for (int s = 0; s < pqnca_pkg::NUM_SUB_DEF; s++)
			load_dist({3'(s), board.center_mem[0][8*s +: 8], query[8*s +: 8]}, '0);
		assign_point(query, 10'h3FF, 1'b0);
		assign_point(query, '0, 1'b0);
		run_random(16, 40);

		// zero clusters acts as one; largest possible sum
		settle();
		write_clusters('0);
		load_center('0, '1);
		for (int s = 0; s < pqnca_pkg::NUM_SUB_DEF; s++)
			load_dist({3'(s), 8'hFF, 8'hFF}, '1);
		assign_point('1, 10'h3FF, 1'b0);
		run_random(16, 40);

		run_phase(11'd1, 16, 45);
		run_phase(11'd5, 24, 45);
		run_phase(11'd37, 24, 40);

		settle();
		if (board.errors == 0 && board.expected_q.size() == 0)
			$display("pq_nearest_center_assign_top: match");
		else
			$display("pq_nearest_center_assign_top: mismatch");
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+sv
sv/pqnca_pkg.sv
sv/pqnca_dpath.sv
sv/pqnca_ctrl.sv
sv/pq_nearest_center_assign_top.sv
sv/pqnca_checker.sv
verif/tb.sv
